// File: design/smc_pkg.sv
// Shared types and codes for the two-way sorted merge with count sum.
`timescale 1ns / 1ps

package smc_pkg;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_PUSH_A = 2'd0,
    KIND_PUSH_B = 2'd1,
    KIND_PULL   = 2'd2
  } kind_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_RECORD    = 3'd0,
    ST_WAIT      = 3'd1,
    ST_DONE      = 3'd2,
    ST_PUSH_OK   = 3'd3,
    ST_PUSH_FULL = 3'd4
  } status_e;

  // One record as held in a queue
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] count;
  } rec_t;

  // Queue status towards the merge control
  typedef struct packed {
    logic empty;
    logic one_left;
    logic full;
    rec_t head;
  } queue_stat_t;

  // Queue command from the merge control
  typedef struct packed {
    logic push;
    logic pop;
  } queue_cmd_t;

  // One result item
  typedef struct packed {
    status_e status;
    rec_t    rec;
    logic    last;
  } res_t;

endpackage

// File: design/sorted_merge_with_count_sum_core.sv
// Top level: request register, two record queues, merge control, result register.
//
//   channel   direction  handshake                  payload
//   request   in         in_valid_i / in_ready_o    kind_i key_id_i value_id_i count_i list_end_i
//   result    out        out_valid_o / out_ready_i  status_o out_key_o out_value_o out_count_o last_o
//
// One request per cycle while the result side keeps up. A request is decided as it leaves
// the request register, and its result is then held in the result register.
// Decisions use queue heads prefetched from each queue's memory read port.
// A stalled result holds the result register and any waiting request; an empty request
// register still takes one request during the stall.
// Reset clears queue pointers, fill counts and end flags; queue memories are not cleared.
`timescale 1ns / 1ps

module sorted_merge_with_count_sum_core #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] key_id_i,
  input  logic [31:0] value_id_i,
  input  logic [31:0] count_i,
  input  logic        list_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_key_o,
  output logic [31:0] out_value_o,
  output logic [31:0] out_count_o,
  output logic        last_o
);
  import smc_pkg::*;

  logic        req_valid_q;
  kind_e       req_kind_q;
  rec_t        req_rec_q;
  logic        req_end_q;
  logic        res_valid_q;
  res_t        res_q;
  res_t        res_d;
  logic        advance;
  logic        fire;
  queue_stat_t stat_a, stat_b;
  queue_cmd_t  cmd_a, cmd_b;

  // Move the pipeline when the result register is free or being taken
  assign advance    = !res_valid_q || out_ready_i;
  assign fire       = req_valid_q && advance;
  assign in_ready_o = !req_valid_q || advance;

  // Request register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_kind_q      <= kind_e'(kind_i);
      req_rec_q.key   <= key_id_i;
      req_rec_q.value <= value_id_i;
      req_rec_q.count <= count_i;
      req_end_q       <= list_end_i;
    end
  end

  smc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_a),
    .wdata_i (req_rec_q),
    .stat_o  (stat_a)
  );

  smc_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_b),
    .wdata_i (req_rec_q),
    .stat_o  (stat_b)
  );

  smc_merge_ctrl u_merge_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .kind_i     (req_kind_q),
    .list_end_i (req_end_q),
    .stat_a_i   (stat_a),
    .stat_b_i   (stat_b),
    .cmd_a_o    (cmd_a),
    .cmd_b_o    (cmd_b),
    .res_o      (res_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign status_o    = res_q.status;
  assign out_key_o   = res_q.rec.key;
  assign out_value_o = res_q.rec.value;
  assign out_count_o = res_q.rec.count;
  assign last_o      = res_q.last;

endmodule

// File: design/smc_queue.sv
// Record FIFO with a single-port-write memory and a prefetched head record.
`timescale 1ns / 1ps

module smc_queue #(
  parameter int unsigned Depth = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  smc_pkg::queue_cmd_t cmd_i,
  input  smc_pkg::rec_t       wdata_i,
  output smc_pkg::queue_stat_t stat_o
);
  import smc_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(Depth);

  rec_t             mem [Depth];
  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] tail_q, tail_d;
  logic [FillW-1:0] fill_q, fill_d;
  rec_t             rd_q;
  rec_t             wdata_q;
  logic             byp_q, byp_d;

  function automatic logic [AddrW-1:0] ptr_inc(input logic [AddrW-1:0] ptr);
    ptr_inc = (ptr == LastAddr) ? '0 : ptr + 1'b1;
  endfunction

  // Advance pointers and fill count
  always_comb begin
    head_d = cmd_i.pop ? ptr_inc(head_q) : head_q;
    tail_d = cmd_i.push ? ptr_inc(tail_q) : tail_q;
    fill_d = fill_q;
    if (cmd_i.push) begin
      fill_d = fill_q + 1'b1;
    end else if (cmd_i.pop) begin
      fill_d = fill_q - 1'b1;
    end
    // a write landing on the entry read this cycle is forwarded
    byp_d = cmd_i.push && (tail_q == head_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
      byp_q  <= 1'b0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
      byp_q  <= byp_d;
    end
  end

  // Record store: write at the tail, read the next head every cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[tail_q] <= wdata_i;
    end
    rd_q    <= mem[head_d];
    wdata_q <= wdata_i;
  end

  assign stat_o.empty    = (fill_q == '0);
  assign stat_o.one_left = (fill_q == FillW'(1));
  assign stat_o.full     = (fill_q == FullFill);
  assign stat_o.head     = byp_q ? wdata_q : rd_q;

endmodule

// File: design/smc_merge_ctrl.sv
// Merge decision: head compare, count sum, end-of-list flags and status.
`timescale 1ns / 1ps

module smc_merge_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  smc_pkg::kind_e       kind_i,
  input  logic                 list_end_i,
  input  smc_pkg::queue_stat_t stat_a_i,
  input  smc_pkg::queue_stat_t stat_b_i,
  output smc_pkg::queue_cmd_t  cmd_a_o,
  output smc_pkg::queue_cmd_t  cmd_b_o,
  output smc_pkg::res_t        res_o
);
  import smc_pkg::*;

  logic ended_a_q, ended_a_d;
  logic ended_b_q, ended_b_d;
  logic a_lt, heads_eq;
  logic push_a, push_b, pop_a, pop_b;
  logic a_left, b_left;

  // Compare heads by key, then by value
  always_comb begin
    heads_eq = (stat_a_i.head.key == stat_b_i.head.key) &&
               (stat_a_i.head.value == stat_b_i.head.value);
    if (stat_a_i.head.key != stat_b_i.head.key) begin
      a_lt = stat_a_i.head.key < stat_b_i.head.key;
    end else begin
      a_lt = stat_a_i.head.value < stat_b_i.head.value;
    end
  end

  // Decide the request's effect and its result
  always_comb begin
    push_a       = 1'b0;
    push_b       = 1'b0;
    pop_a        = 1'b0;
    pop_b        = 1'b0;
    a_left       = 1'b0;
    b_left       = 1'b0;
    ended_a_d    = ended_a_q;
    ended_b_d    = ended_b_q;
    res_o        = '0;
    res_o.status = ST_WAIT;
    unique case (kind_i)
      KIND_PUSH_A: begin
        push_a       = !stat_a_i.full;
        res_o.status = stat_a_i.full ? ST_PUSH_FULL : ST_PUSH_OK;
        if (push_a && list_end_i) begin
          ended_a_d = 1'b1;
        end
      end
      KIND_PUSH_B: begin
        push_b       = !stat_b_i.full;
        res_o.status = stat_b_i.full ? ST_PUSH_FULL : ST_PUSH_OK;
        if (push_b && list_end_i) begin
          ended_b_d = 1'b1;
        end
      end
      KIND_PULL: begin
        priority if (!stat_a_i.empty && !stat_b_i.empty) begin
          pop_a = a_lt || heads_eq;
          pop_b = !a_lt;
        end else if (!stat_a_i.empty) begin
          pop_a = ended_b_q;
        end else if (!stat_b_i.empty) begin
          pop_b = ended_a_q;
        end else if (ended_a_q && ended_b_q) begin
          res_o.status = ST_DONE;
          ended_a_d    = 1'b0;
          ended_b_d    = 1'b0;
        end
        if (pop_a || pop_b) begin
          res_o.status = ST_RECORD;
          res_o.rec    = pop_a ? stat_a_i.head : stat_b_i.head;
          if (pop_a && pop_b) begin
            res_o.rec.count = stat_a_i.head.count + stat_b_i.head.count;
          end
          a_left     = !stat_a_i.empty && !(pop_a && stat_a_i.one_left);
          b_left     = !stat_b_i.empty && !(pop_b && stat_b_i.one_left);
          res_o.last = ended_a_q && ended_b_q && !a_left && !b_left;
        end
      end
      default: begin
        res_o.status = ST_WAIT;
      end
    endcase
  end

  assign cmd_a_o.push = fire_i && push_a;
  assign cmd_a_o.pop  = fire_i && pop_a;
  assign cmd_b_o.push = fire_i && push_b;
  assign cmd_b_o.pop  = fire_i && pop_b;

  // Hold end flags until the request takes effect
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ended_a_q <= 1'b0;
      ended_b_q <= 1'b0;
    end else if (fire_i) begin
      ended_a_q <= ended_a_d;
      ended_b_q <= ended_b_d;
    end
  end

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the two-way sorted merge with count sum.
`timescale 1ns / 1ps

module testbench;
  import smc_pkg::*;

  localparam int unsigned DEPTH           = 256;
  localparam int unsigned RANDOM_REQUESTS = 300;
  localparam logic [1:0]  KIND_SPARE      = 2'd3;
  localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;

  logic        clk;
  logic        rst_n;
  logic        req_valid;
  logic        req_ready;
  logic [1:0]  req_kind;
  logic [31:0] req_key;
  logic [31:0] req_value;
  logic [31:0] req_count;
  logic        req_end;
  logic        res_valid;
  logic        res_ready;
  logic [2:0]  res_status;
  logic [31:0] res_key;
  logic [31:0] res_value;
  logic [31:0] res_count;
  logic        res_last;

  // Mirror of the block: both record lists and their end flags
  rec_t        list_a[$];
  rec_t        list_b[$];
  bit          ended_a;
  bit          ended_b;

  res_t        pending_results[$];
  int unsigned mismatches;
  int unsigned requests_sent;
  bit          calm;

  sorted_merge_with_count_sum_core #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .kind_i     (req_kind),
    .key_id_i   (req_key),
    .value_id_i (req_value),
    .count_i    (req_count),
    .list_end_i (req_end),
    .out_valid_o(res_valid),
    .out_ready_i(res_ready),
    .status_o   (res_status),
    .out_key_o  (res_key),
    .out_value_o(res_value),
    .out_count_o(res_count),
    .last_o     (res_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle cycles before a request or a result; none while calm
  function automatic int unsigned draw_idle();
    if (calm) return 0;
    return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 13);
  endfunction

  // Mostly small ids so that lists collide, with the extremes mixed in
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return ALL_ONES;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 5);
    endcase
  endfunction

  // Apply one request to the mirror and return the result it should give
  function automatic res_t merge_step(input logic [1:0] kind, input rec_t rec,
                                      input logic end_flag);
    res_t        r;
    bit          take_a;
    bit          take_b;
    logic [63:0] order_a;
    logic [63:0] order_b;
    r      = '0;
    r.status = ST_WAIT;
    take_a = 1'b0;
    take_b = 1'b0;
    case (kind)
      KIND_PUSH_A: begin
        if (list_a.size() >= DEPTH) begin
          r.status = ST_PUSH_FULL;
        end else begin
          list_a.push_back(rec);
          if (end_flag) ended_a = 1'b1;
          r.status = ST_PUSH_OK;
        end
      end
      KIND_PUSH_B: begin
        if (list_b.size() >= DEPTH) begin
          r.status = ST_PUSH_FULL;
        end else begin
          list_b.push_back(rec);
          if (end_flag) ended_b = 1'b1;
          r.status = ST_PUSH_OK;
        end
      end
      KIND_PULL: begin
        if (list_a.size() > 0 && list_b.size() > 0) begin
          order_a = {list_a[0].key, list_a[0].value};
          order_b = {list_b[0].key, list_b[0].value};
          take_a  = (order_a <= order_b);
          take_b  = (order_a >= order_b);
        end else if (list_a.size() > 0) begin
          take_a = ended_b;
        end else if (list_b.size() > 0) begin
          take_b = ended_a;
        end else if (ended_a && ended_b) begin
          r.status = ST_DONE;
          ended_a  = 1'b0;
          ended_b  = 1'b0;
        end
        if (take_a || take_b) begin
          r.status = ST_RECORD;
          r.rec    = take_a ? list_a[0] : list_b[0];
          // Equal heads merge into one record; the sum wraps at 32 bits
          if (take_a && take_b) r.rec.count = list_a[0].count + list_b[0].count;
          if (take_a) list_a.delete(0);
          if (take_b) list_b.delete(0);
          r.last = ended_a && ended_b && list_a.size() == 0 && list_b.size() == 0;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Drive one request, queue its expected result and hold until accepted
  task automatic send_request(input logic [1:0] kind, input logic [31:0] key,
                              input logic [31:0] value, input logic [31:0] count,
                              input logic end_flag, output res_t predicted);
    int unsigned gap;
    rec_t        rec;
    gap = draw_idle();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rec.key   = key;
    rec.value = value;
    rec.count = count;
    predicted = merge_step(kind, rec, end_flag);
    pending_results.push_back(predicted);
    requests_sent++;
    req_valid <= 1'b1;
    req_kind  <= kind;
    req_key   <= key;
    req_value <= value;
    req_count <= count;
    req_end   <= end_flag;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic pull(output res_t predicted);
    send_request(KIND_PULL, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                 predicted);
  endtask

  // Hold the request side until every expected result has come back
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Walk every request kind through the corner cases of the merge
  task automatic test_directed();
    res_t got;
    pull(got);                                                    // nothing pushed
    send_request(KIND_SPARE, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, got);
    send_request(KIND_PUSH_B, 32'd1, 32'd1, 32'd1, 1'b1, got);
    pull(got);                                                    // A empty, not ended
    send_request(KIND_PUSH_A, 32'd0, 32'd0, 32'd5, 1'b0, got);
    send_request(KIND_PUSH_A, 32'd1, 32'd1, ALL_ONES, 1'b0, got);
    pull(got);                                                    // A lower
    pull(got);                                                    // equal heads, sum wraps
    pull(got);                                                    // both empty, one ended
    send_request(KIND_PUSH_A, 32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 1'b0, got);
    send_request(KIND_PUSH_A, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, got);
    send_request(KIND_PUSH_B, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 1'b0, got);
    send_request(KIND_SPARE, 32'd0, 32'd0, 32'd0, 1'b0, got);
    pull(got);                                                    // B lower
    pull(got);                                                    // B drained and ended
    pull(got);                                                    // final record
    pull(got);                                                    // done
    pull(got);                                                    // flags cleared
    send_request(KIND_PUSH_B, 32'd0, ALL_ONES, 32'd0, 1'b1, got);
    send_request(KIND_PUSH_A, 32'd0, ALL_ONES, 32'd1, 1'b1, got);
    pull(got);
    pull(got);
  endtask

  // Fill both queues with matching records, push into full ones, then drain through the wrap
  task automatic test_queue_full();
    res_t        got;
    int unsigned i;
    calm = 1'b1;
    for (i = 0; i < DEPTH; i++) begin
      send_request(KIND_PUSH_A, i, i, $urandom, 1'b0, got);
      send_request(KIND_PUSH_B, i, i, $urandom, 1'b0, got);
    end
    calm = 1'b0;
    // Full: dropped, and the end flag must not stick
    send_request(KIND_PUSH_A, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, got);
    send_request(KIND_PUSH_B, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, got);
    drain_results();
    repeat (DEPTH) pull(got);
    pull(got);
    send_request(KIND_PUSH_A, 32'hFFFF_FFF0, 32'd0, 32'd7, 1'b1, got);
    pull(got);
    send_request(KIND_PUSH_B, 32'hFFFF_FFF1, 32'd0, 32'd9, 1'b1, got);
    pull(got);
    pull(got);
    pull(got);
  endtask

  // Random, mostly sorted lists that share records, interleaved with pulls and spare-kind requests
  task automatic test_random_merges();
    rec_t        pool[$];
    rec_t        lane_a[$];
    rec_t        lane_b[$];
    rec_t        item;
    res_t        got;
    int unsigned start;
    int unsigned pos;
    int unsigned n;
    int unsigned pick;
    int unsigned ia;
    int unsigned ib;
    int unsigned extra_pulls;
    bit          finished;
    start = requests_sent;
    while (requests_sent - start < RANDOM_REQUESTS) begin
      calm = ($urandom_range(0, 4) == 0);
      pool.delete();
      lane_a.delete();
      lane_b.delete();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
      // Build a sorted pool of distinct (key, value) pairs
      repeat (n) begin
        item.key   = pick_word();
        item.value = pick_word();
        item.count = 32'd0;
        pos = 0;
        while (pos < pool.size() &&
               {pool[pos].key, pool[pos].value} < {item.key, item.value}) pos++;
        if (pos == pool.size() ||
            {pool[pos].key, pool[pos].value} != {item.key, item.value})
          pool.insert(pos, item);
      end
      // Deal the pool into A, B or both
      foreach (pool[i]) begin
        pick = $urandom_range(0, 4);
        item = pool[i];
        if (pick <= 1 || pick == 4) begin
          item.count = pick_word();
          lane_a.push_back(item);
        end
        if (pick >= 2) begin
          item.count = pick_word();
          lane_b.push_back(item);
        end
      end
      if (lane_a.size() == 0) begin
        item = pool[0];
        item.count = $urandom;
        lane_a.push_back(item);
      end
      if (lane_b.size() == 0) begin
        item = pool[pool.size() - 1];
        item.count = $urandom;
        lane_b.push_back(item);
      end
      // Now and then break the ordering of list A
      if ($urandom_range(0, 7) == 0 && lane_a.size() > 1) begin
        item = lane_a[0];
        lane_a[0] = lane_a[lane_a.size() - 1];
        lane_a[lane_a.size() - 1] = item;
      end
      ia = 0;
      ib = 0;
      extra_pulls = 0;
      finished = 1'b0;
      while (!finished) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          send_request(KIND_SPARE, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                       got);
        end else if (pick <= 7 && ia < lane_a.size()) begin
          send_request(KIND_PUSH_A, lane_a[ia].key, lane_a[ia].value, lane_a[ia].count,
                       ia == lane_a.size() - 1, got);
          ia++;
        end else if (pick <= 14 && ib < lane_b.size()) begin
          send_request(KIND_PUSH_B, lane_b[ib].key, lane_b[ib].value, lane_b[ib].count,
                       ib == lane_b.size() - 1, got);
          ib++;
        end else begin
          pull(got);
          if (ia == lane_a.size() && ib == lane_b.size()) extra_pulls++;
          finished = (got.status == ST_DONE) || (extra_pulls > 200);
        end
      end
    end
    calm = 1'b0;
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin : result_check
    res_t seen;
    res_t want;
    if (rst_n && res_valid && res_ready) begin
      seen.status    = status_e'(res_status);
      seen.rec.key   = res_key;
      seen.rec.value = res_value;
      seen.rec.count = res_count;
      seen.last      = res_last;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: st=%0d k=%h v=%h c=%h last=%0d",
                   seen.status, seen.rec.key, seen.rec.value, seen.rec.count, seen.last);
      end else begin
        want = pending_results.pop_front();
        if (seen.status !== want.status || seen.rec.key !== want.rec.key ||
            seen.rec.value !== want.rec.value || seen.rec.count !== want.rec.count ||
            seen.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: want st=%0d k=%h v=%h c=%h last=%0d,",
                      " got st=%0d k=%h v=%h c=%h last=%0d"},
                     want.status, want.rec.key, want.rec.value, want.rec.count, want.last,
                     seen.status, seen.rec.key, seen.rec.value, seen.rec.count, seen.last);
        end
      end
    end
  end

  // Stall the result side at random
  initial begin
    int unsigned stall;
    res_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_idle();
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  // Give up on a hung run
  initial begin
    #5_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    int unsigned settle;
    clk           = 1'b0;
    calm          = 1'b0;
    mismatches    = 0;
    requests_sent = 0;
    ended_a       = 1'b0;
    ended_b       = 1'b0;
    rst_n     <= 1'b0;
    req_valid <= 1'b0;
    req_kind  <= KIND_PULL;
    req_key   <= '0;
    req_value <= '0;
    req_count <= '0;
    req_end   <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    drain_results();
    test_queue_full();
    drain_results();
    test_random_merges();
    drain_results();

    // Let any straggling result show up
    settle = 0;
    while (settle < 10) begin
      @(posedge clk);
      settle++;
    end
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: files.f
design/smc_pkg.sv
design/smc_queue.sv
design/smc_merge_ctrl.sv
design/sorted_merge_with_count_sum_core.sv
tb/testbench.sv
